/* hdl/aa_rounded_corner_pixel_assert.svh */
// assertion macros for the rounded corner pixel unit
// RCP_ASSERT expects clk_i and rst_ni in the scope of use, RCP_ASSERT_ALWAYS only clk_i
`ifndef AA_ROUNDED_CORNER_PIXEL_ASSERT_SVH
`define AA_ROUNDED_CORNER_PIXEL_ASSERT_SVH

`ifndef SYNTHESIS

// checked on every edge once reset is released
`define RCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rcp assertion failed");

// checked on every edge, reset included
`define RCP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rcp assertion failed");

`else

`define RCP_ASSERT(lbl, prop)

`define RCP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

/* hdl/rcp_pkg.sv */
`timescale 1ns / 1ps

package rcp_pkg;

  localparam int unsigned OffW    = 7;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned PixW    = 14;
  localparam int unsigned ColorW  = 32;
  localparam int unsigned D2W     = 16;
  localparam int unsigned RootW   = 16;
  localparam int unsigned RemW    = 19;
  localparam int unsigned RadW    = 16;
  localparam int unsigned NumCells = 16;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_CENTER_X   = 3'd0,
    CFG_CENTER_Y   = 3'd1,
    CFG_RADIUS     = 3'd2,
    CFG_FILL_COLOR = 3'd3,
    CFG_QUADRANT   = 3'd4
  } rcp_cfg_e;

  typedef enum logic [1:0] {
    QUAD_TOP_LEFT     = 2'd0,
    QUAD_TOP_RIGHT    = 2'd1,
    QUAD_BOTTOM_LEFT  = 2'd2,
    QUAD_BOTTOM_RIGHT = 2'd3
  } rcp_quad_e;

  // where the pixel lies against the anti-aliased ring
  typedef enum logic [1:0] {
    ZONE_EDGE = 2'd0,
    ZONE_IN   = 2'd1,
    ZONE_OUT  = 2'd2
  } rcp_zone_e;

  // running state of the digit-by-digit square root
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
  } rcp_sqrt_t;

  // item data riding along the cell chain
  typedef struct packed {
    logic [PixW-1:0]   px;
    logic [PixW-1:0]   py;
    logic [ColorW-1:0] bg;
    rcp_zone_e         zone;
  } rcp_pass_t;

endpackage

/* hdl/rcp_sqrt_cell.sv */
`timescale 1ns / 1ps

module rcp_sqrt_cell
  import rcp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  rcp_sqrt_t sq_i,
  input  rcp_pass_t pass_i,
  output logic      valid_o,
  output rcp_sqrt_t sq_o,
  output rcp_pass_t pass_o
);

  logic      valid_q;
  rcp_sqrt_t sq_q, sq_d;
  rcp_pass_t pass_q;

  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;

  // one result bit: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh = {sq_i.rem[RemW-3:0], sq_i.rad[RadW-1 -: 2]};
    trial  = {1'b0, sq_i.root, 2'b01};
    sq_d.rad = {sq_i.rad[RadW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      sq_d.rem  = rem_sh - trial;
      sq_d.root = {sq_i.root[RootW-2:0], 1'b1};
    end else begin
      sq_d.rem  = rem_sh;
      sq_d.root = {sq_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= sq_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;
  assign pass_o  = pass_q;

endmodule

/* hdl/rcp_blend.sv */
`timescale 1ns / 1ps

module rcp_blend
  import rcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [RootW-1:0]   root_i,
  input  rcp_pass_t          pass_i,
  input  logic [OffW-1:0]    radius_i,
  input  logic [ColorW-1:0]  fill_i,
  output logic               valid_o,
  output logic [PixW-1:0]    px_o,
  output logic [PixW-1:0]    py_o,
  output logic [7:0]         alpha_o,
  output logic [ColorW-1:0]  color_o
);

  // (fg*a + bg*(255-a)) / 255, division as add-and-shift (exact below 65535)
  function automatic logic [7:0] mix(input logic [7:0] fg, input logic [7:0] bg,
                                     input logic [7:0] a);
    logic [7:0]  na;
    logic [15:0] num;
    logic [16:0] sum;
    na  = ~a;
    num = fg * a + bg * na;
    sum = {1'b0, num} + {9'd0, num[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  // alpha stage
  logic              a_valid_q;
  logic [7:0]        alpha_d, alpha_q;
  logic [PixW-1:0]   a_px_q, a_py_q;
  logic [ColorW-1:0] a_bg_q;
  logic signed [16:0] diff;

  always_comb begin
    diff = $signed({2'b00, radius_i, 8'd0}) - $signed({1'b0, root_i});
    case (pass_i.zone)
      ZONE_IN:   alpha_d = 8'hFF;
      ZONE_OUT:  alpha_d = 8'h00;
      ZONE_EDGE: begin
        if (diff < 0)             alpha_d = 8'h00;
        else if (diff > 17'sd255) alpha_d = 8'hFF;
        else                      alpha_d = diff[7:0];
      end
      default:   alpha_d = 8'h00;
    endcase
  end

  // output stage
  logic              o_valid_q;
  logic [ColorW-1:0] color_d, color_q;
  logic [PixW-1:0]   o_px_q, o_py_q;
  logic [7:0]        o_alpha_q;

  always_comb begin
    if (alpha_q == 8'h00) begin
      color_d = '0;
    end else if (alpha_q == 8'hFF) begin
      color_d = fill_i;
    end else begin
      color_d = {8'h00,
                 mix(fill_i[23:16], a_bg_q[23:16], alpha_q),
                 mix(fill_i[15:8],  a_bg_q[15:8],  alpha_q),
                 mix(fill_i[7:0],   a_bg_q[7:0],   alpha_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      o_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      alpha_q   <= alpha_d;
      a_px_q    <= pass_i.px;
      a_py_q    <= pass_i.py;
      a_bg_q    <= pass_i.bg;
      color_q   <= color_d;
      o_alpha_q <= alpha_q;
      o_px_q    <= a_px_q;
      o_py_q    <= a_py_q;
    end
  end

  assign valid_o = o_valid_q;
  assign px_o    = o_px_q;
  assign py_o    = o_py_q;
  assign alpha_o = o_alpha_q;
  assign color_o = color_q;

endmodule

/* hdl/aa_rounded_corner_pixel.sv */
`timescale 1ns / 1ps

// Anti-aliased rounded corner pixel unit. Each item names one pixel of a
// corner square by its column and row offset from the corner centre and
// carries the frame buffer pixel found there; the unit returns the screen
// coordinate, a coverage alpha, a write flag and the color to write. Items
// flow through 19 register stages (input register, sixteen square-root
// cells, alpha register, output register), and a new item is taken every
// clock while the output side keeps up. The
// distance root floor(sqrt(d2 * 65536)) is built one result bit per cell
// down the chain; a stall on the output side holds the whole chain.
// Configuration is taken at any edge with cfg_we_i high and should only be
// written while the unit is empty.

module aa_rounded_corner_pixel
  import rcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // col_offset, row_offset, background, pad
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // pixel_x, pixel_y, coverage, pixel_color, pad
  output logic [0:0]  m_axis_tuser_o    // write_pixel
);

`include "aa_rounded_corner_pixel_assert.svh"

  // configuration registers
  logic [CoordW-1:0] center_x_q, center_y_q;
  logic [OffW-1:0]   radius_q;
  logic [ColorW-1:0] fill_q;
  rcp_quad_e         quad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= OffW'(8);
      fill_q     <= '0;
      quad_q     <= QUAD_TOP_LEFT;
    end else if (cfg_we_i) begin
      case (rcp_cfg_e'(cfg_addr_i))
        CFG_CENTER_X:   center_x_q <= cfg_wdata_i[CoordW-1:0];
        CFG_CENTER_Y:   center_y_q <= cfg_wdata_i[CoordW-1:0];
        CFG_RADIUS:     radius_q   <= cfg_wdata_i[OffW-1:0];
        CFG_FILL_COLOR: fill_q     <= cfg_wdata_i;
        CFG_QUADRANT:   quad_q     <= rcp_quad_e'(cfg_wdata_i[1:0]);
        default:        ; // indexes past the list are dropped
      endcase
    end
  end

  // whole chain moves together unless a result is waiting on the output
  logic adv;
  assign adv = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // input fields
  logic [OffW-1:0]   dx, dy;
  logic [ColorW-1:0] bg_in;
  assign dx    = s_axis_tdata_i[6:0];
  assign dy    = s_axis_tdata_i[13:7];
  assign bg_in = s_axis_tdata_i[45:14];

  // front stage: screen coordinate and squared distance
  logic              right, bottom;
  logic [PixW-1:0]   px_d, py_d;
  logic [OffW:0]     dx1, dy1;
  logic [2*OffW:0]   dx_sq, dy_sq;
  logic [D2W-1:0]    d2_d;

  always_comb begin
    right  = (quad_q == QUAD_TOP_RIGHT) || (quad_q == QUAD_BOTTOM_RIGHT);
    bottom = (quad_q == QUAD_BOTTOM_LEFT) || (quad_q == QUAD_BOTTOM_RIGHT);
    // left and top pixels sit one step before the centre
    px_d = right ? ({2'b00, center_x_q} + {7'd0, dx})
                 : ({2'b00, center_x_q} - PixW'(1) - {7'd0, dx});
    py_d = bottom ? ({2'b00, center_y_q} + {7'd0, dy})
                  : ({2'b00, center_y_q} - PixW'(1) - {7'd0, dy});
    dx1   = {1'b0, dx} + 8'd1;
    dy1   = {1'b0, dy} + 8'd1;
    dx_sq = dx1 * dx1;
    dy_sq = dy1 * dy1;
    d2_d  = {1'b0, dx_sq} + {1'b0, dy_sq};
  end

  logic              f_valid_q;
  logic [PixW-1:0]   f_px_q, f_py_q;
  logic [ColorW-1:0] f_bg_q;
  logic [D2W-1:0]    f_d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (adv) begin
      f_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_px_q <= px_d;
      f_py_q <= py_d;
      f_bg_q <= bg_in;
      f_d2_q <= d2_d;
    end
  end

  // ring test against radius^2 and (radius-1)^2; radius zero gives an inner square of one
  logic [OffW-1:0]     rm1;
  logic [2*OffW-1:0]   r_sq, rin_sq;
  rcp_zone_e           zone;

  always_comb begin
    rm1    = (radius_q == '0) ? OffW'(1) : radius_q - OffW'(1);
    r_sq   = radius_q * radius_q;
    rin_sq = rm1 * rm1;
    if ({2'b00, rin_sq} > f_d2_q)      zone = ZONE_IN;
    else if (f_d2_q >= {2'b00, r_sq})  zone = ZONE_OUT;
    else                               zone = ZONE_EDGE;
  end

  // square-root cell chain
  logic      c_valid [NumCells+1];
  rcp_sqrt_t c_sq    [NumCells+1];
  rcp_pass_t c_pass  [NumCells+1];

  assign c_valid[0]      = f_valid_q;
  assign c_sq[0].rem     = '0;
  assign c_sq[0].root    = '0;
  assign c_sq[0].rad     = f_d2_q;  // d2 * 65536: low pairs come in as zeros
  assign c_pass[0].px    = f_px_q;
  assign c_pass[0].py    = f_py_q;
  assign c_pass[0].bg    = f_bg_q;
  assign c_pass[0].zone  = zone;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    rcp_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (c_valid[g]),
      .sq_i    (c_sq[g]),
      .pass_i  (c_pass[g]),
      .valid_o (c_valid[g+1]),
      .sq_o    (c_sq[g+1]),
      .pass_o  (c_pass[g+1])
    );
  end

  // coverage and color
  logic [PixW-1:0]   o_px, o_py;
  logic [7:0]        o_alpha;
  logic [ColorW-1:0] o_color;

  rcp_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (c_valid[NumCells]),
    .root_i   (c_sq[NumCells].root),
    .pass_i   (c_pass[NumCells]),
    .radius_i (radius_q),
    .fill_i   (fill_q),
    .valid_o  (m_axis_tvalid_o),
    .px_o     (o_px),
    .py_o     (o_py),
    .alpha_o  (o_alpha),
    .color_o  (o_color)
  );

  assign m_axis_tdata_o = {4'd0, o_color, o_alpha, o_py, o_px};
  assign m_axis_tuser_o = (o_alpha != 8'h00);

  // no coverage means nothing to paint
  `RCP_ASSERT(a_none_black, m_axis_tvalid_o && (o_alpha == 8'h00) |-> (o_color == '0))
  // full coverage passes the fill color through whole
  `RCP_ASSERT(a_full_fill, m_axis_tvalid_o && (o_alpha == 8'hFF) |-> (o_color == fill_q))
  // partial coverage clears the alpha byte
  `RCP_ASSERT(a_edge_top, m_axis_tvalid_o && (o_alpha != 8'h00) && (o_alpha != 8'hFF)
              |-> (o_color[31:24] == 8'h00))
  // a held result keeps its coverage
  `RCP_ASSERT(a_hold_alpha, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(o_alpha))
  // the chain never takes an item while the output is blocked
  `RCP_ASSERT_ALWAYS(a_no_take_stall, !(m_axis_tvalid_o && !m_axis_tready_i) || !s_axis_tready_o)

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rcp_pkg::*;

  // one expected result item, fields at the block's widths
  typedef struct {
    logic [13:0] px;
    logic [13:0] py;
    logic [7:0]  cov;
    logic        wr;
    logic [31:0] color;
  } corner_px_t;

  // keeps its own copy of the registers and predicts each pixel in order
  class pixel_scoreboard;
    logic [11:0] cx;
    logic [11:0] cy;
    logic [6:0]  radius;
    logic [31:0] fill;
    rcp_quad_e   quad;
    corner_px_t  expected_q[$];
    int unsigned errors;

    function new();
      cx = '0;
      cy = '0;
      radius = 7'd8;
      fill = '0;
      quad = QUAD_TOP_LEFT;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        CFG_CENTER_X:   cx = value[11:0];
        CFG_CENTER_Y:   cy = value[11:0];
        CFG_RADIUS:     radius = value[6:0];
        CFG_FILL_COLOR: fill = value;
        CFG_QUADRANT:   quad = rcp_quad_e'(value[1:0]);
        default: ;
      endcase
    endfunction

    function int unsigned root_floor(longint unsigned n);
      int unsigned res;
      int unsigned t;
      res = 0;
      for (int b = 15; b >= 0; b--) begin
        t = res | (32'd1 << b);
        if (longint'(t) * longint'(t) <= n) res = t;
      end
      return res;
    endfunction

    function int unsigned blend(int unsigned f, int unsigned b, int unsigned a);
      return (f * a + b * (255 - a)) / 255;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [6:0] col, logic [6:0] row, logic [31:0] bg);
      corner_px_t e;
      int r;
      int px;
      int py;
      int d2;
      int diff;
      int unsigned a;
      bit right;
      bit bottom;
      r = radius;
      right = (quad == QUAD_TOP_RIGHT) || (quad == QUAD_BOTTOM_RIGHT);
      bottom = (quad == QUAD_BOTTOM_LEFT) || (quad == QUAD_BOTTOM_RIGHT);
      px = right ? int'(cx) + int'(col) : int'(cx) - 1 - int'(col);
      py = bottom ? int'(cy) + int'(row) : int'(cy) - 1 - int'(row);
      d2 = (int'(col) + 1) * (int'(col) + 1) + (int'(row) + 1) * (int'(row) + 1);
      if (d2 < (r - 1) * (r - 1)) a = 255;
      else if (d2 >= r * r) a = 0;
      else begin
        diff = r * 256 - int'(root_floor(longint'(d2) * 65536));
        if (diff < 0) diff = 0;
        if (diff > 255) diff = 255;
        a = diff;
      end
      e.px = px[13:0];
      e.py = py[13:0];
      e.cov = a[7:0];
      e.wr = (a != 0);
      if (a == 0) e.color = '0;
      else if (a == 255) e.color = fill;
      else begin
        e.color[31:24] = 8'h00;
        e.color[23:16] = 8'(blend(fill[23:16], bg[23:16], a));
        e.color[15:8]  = 8'(blend(fill[15:8], bg[15:8], a));
        e.color[7:0]   = 8'(blend(fill[7:0], bg[7:0], a));
      end
      expected_q.push_back(e);
    endfunction

    function void match(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [71:0] data, logic [0:0] user);
      corner_px_t e;
      if (expected_q.size() == 0) begin
        $error("result item with no expected pixel waiting");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      match("pixel_x", e.px, data[13:0]);
      match("pixel_y", e.py, data[27:14]);
      match("coverage", e.cov, data[35:28]);
      match("pixel_color", e.color, data[67:36]);
      match("write_pixel", e.wr, user[0]);
    endfunction
  endclass

  localparam int unsigned Latency    = 19;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandPhases = 14;
  localparam int unsigned PhaseItems = 75;
  // indexes past the last register, writes there must change nothing
  localparam int unsigned SpareFirst = CFG_QUADRANT + 1;
  localparam int unsigned SpareLast  = (1 << $bits(rcp_cfg_e)) - 1;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [31:0] cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;   // col_offset, row_offset, background, pad
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [71:0] m_axis_tdata_o;   // pixel_x, pixel_y, coverage, pixel_color, pad
  logic [0:0]  m_axis_tuser_o;   // write_pixel

  pixel_scoreboard sb;
  int unsigned cycle_count;
  // per-phase switches for stretches with no idling on either side
  bit in_quiet;
  bit out_quiet;

  aa_rounded_corner_pixel dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog, reckoned far above the slowest legal run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** aa_rounded_corner_pixel: FAILED **");
      $finish;
    end
  end

  // one register write, takes effect at the next edge
  task automatic cfg_write(logic [2:0] idx, logic [31:0] value, int unsigned width);
    logic [31:0] mask;
    logic [31:0] data;
    mask = (width >= 32) ? '1 : ((32'd1 << width) - 1);
    data = value & mask;
    // unused upper bits sometimes carry junk, the block must drop it
    if ($urandom_range(0, 3) == 0) data = data | ($urandom & ~mask);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // writes to the unused indexes
  task automatic spare_writes();
    for (int unsigned i = SpareFirst; i <= SpareLast; i++) cfg_write(3'(i), $urandom, 32);
  endtask

  // send one item, with a random gap in front unless this phase runs flat out
  task automatic put(logic [6:0] col, logic [6:0] row, logic [31:0] bg);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {2'b00, bg, row, col};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_input(col, row, bg);
  endtask

  // drain the pipeline so the registers can be rewritten safely
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    cfg_we_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // all five registers, written one after another
  task automatic write_all(logic [11:0] cx, logic [11:0] cy, logic [6:0] r,
                           logic [31:0] fill, rcp_quad_e q);
    cfg_write(CFG_CENTER_X, cx, 12);
    cfg_write(CFG_CENTER_Y, cy, 12);
    cfg_write(CFG_RADIUS, r, 7);
    cfg_write(CFG_FILL_COLOR, fill, 32);
    cfg_write(CFG_QUADRANT, q, 2);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] pick_radius();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd127;
      3, 4: return 7'($urandom_range(2, 8));
      default: return 7'($urandom_range(1, 127));
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly offsets inside the corner square, many of them on the ring
  // where coverage is partial, plus some anywhere from 0 to 126
  task automatic pick_offsets(output logic [6:0] col, output logic [6:0] row);
    int r;
    int top;
    int rq;
    int rv;
    int unsigned kind;
    r = sb.radius;
    top = (r > 1) ? r - 1 : 0;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      col = 7'($urandom_range(0, 126));
      row = 7'($urandom_range(0, 126));
    end else if (kind < 5) begin
      col = 7'($urandom_range(0, top));
      row = 7'($urandom_range(0, top));
    end else begin
      col = 7'($urandom_range(0, top));
      rq = r * r - (int'(col) + 1) * (int'(col) + 1);
      if (rq <= 0) rv = $urandom_range(0, top);
      else rv = int'(sb.root_floor(rq)) - 2 + int'($urandom_range(0, 2));
      if (rv < 0) rv = 0;
      if (rv > 126) rv = 126;
      row = 7'(rv);
    end
  endtask

  // result side: random stall before each item, then take it and check it
  task automatic drain_results();
    int unsigned stall;
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  endtask

  initial begin
    logic [6:0] col;
    logic [6:0] row;
    logic [31:0] bg;
    sb = new();
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_addr_i <= '0;
    cfg_wdata_i <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    m_axis_tready_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      drain_results();
    join_none

    // reset settings: centre at origin, top left, so coordinates go negative
    put(7'd0, 7'd0, 32'h0000_0000);
    put(7'd5, 7'd4, 32'h1234_5678);    // on the ring of radius 8
    put(7'd7, 7'd7, 32'hFFFF_FFFF);    // past the radius
    put(7'd126, 7'd126, 32'hFFFF_FFFF);
    settle();

    // largest centre, largest radius, white fill, bottom right quadrant
    write_all(12'hFFF, 12'hFFF, 7'd127, 32'hFFFF_FFFF, QUAD_BOTTOM_RIGHT);
    spare_writes();
    cfg_we_i <= 1'b0;
    put(7'd0, 7'd0, 32'h0000_0000);    // full coverage keeps the alpha byte
    put(7'd88, 7'd89, 32'h0000_0000);  // partial
    put(7'd89, 7'd89, 32'hA5A5_5A5A);  // just outside
    put(7'd126, 7'd0, 32'h0F0F_F0F0);  // d2 one above radius squared
    put(7'd125, 7'd0, 32'hFFFF_FFFF);  // just inside the ring
    put(7'd126, 7'd126, 32'hFFFF_FFFF);  // largest coordinates
    settle();

    // origin, top left, black fill blended over white
    write_all(12'd0, 12'd0, 7'd127, 32'h0000_0000, QUAD_TOP_LEFT);
    put(7'd126, 7'd126, 32'h0000_0000);  // most negative coordinates
    put(7'd88, 7'd89, 32'hFFFF_FFFF);
    settle();

    // zero radius covers nothing
    write_all(12'd100, 12'd200, 7'd0, 32'h8040_2010, QUAD_TOP_RIGHT);
    put(7'd0, 7'd0, 32'h1122_3344);
    settle();

    // radius one: even the nearest pixel is outside
    write_all(12'd300, 12'd40, 7'd1, 32'h8040_2010, QUAD_BOTTOM_LEFT);
    put(7'd0, 7'd0, 32'h1122_3344);
    settle();

    // radius two: nearest pixel is partial, next is outside
    cfg_write(CFG_RADIUS, 7'd2, 7);
    cfg_we_i <= 1'b0;
    put(7'd0, 7'd0, 32'hC3C3_3C3C);
    put(7'd1, 7'd0, 32'hC3C3_3C3C);
    settle();

    // random settings and items; some phases run with no idling at all
    for (int p = 0; p < RandPhases; p++) begin
      write_all(pick_coord(), pick_coord(), pick_radius(), pick_color(),
                rcp_quad_e'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0) spare_writes();
      cfg_we_i <= 1'b0;
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PhaseItems; i++) begin
        pick_offsets(col, row);
        bg = pick_color();
        put(col, row, bg);
      end
      settle();
    end

    // let any stray result item show up before the verdict
    repeat (Latency + 20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** aa_rounded_corner_pixel: PASSED **");
    end else begin
      $display("** aa_rounded_corner_pixel: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/rcp_pkg.sv
hdl/rcp_sqrt_cell.sv
hdl/rcp_blend.sv
hdl/aa_rounded_corner_pixel.sv
verif/testbench.sv
